FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the hld_lca_query RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

FILE: rtl/core/hld_pkg.sv
// Shared types and constants of the heavy-light LCA query block.
// No dependencies; imported by every module of the block.
`default_nettype none

package hld_pkg;

   localparam int NODE_W        = 10;
   localparam int DEF_MAX_NODES = 1024;
   localparam int REQ_DATA_W    = 56;
   localparam int RSP_DATA_W    = 16;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef logic [NODE_W-1:0] node_type;

   typedef struct packed {
      node_type parent;
      node_type depth;
      node_type head;
   } entry_type;

   typedef struct packed {
      logic      en;
      node_type  node;
      entry_type entry;
   } tbl_wr_type;

   typedef struct packed {
      logic     en;
      node_type node;
   } tbl_rd_type;

   typedef struct packed {
      logic     busy;
      logic     done;
      node_type ancestor;
   } walk_sts_type;

endpackage

`default_nettype wire

FILE: rtl/core/hld_table.sv
// Node table memory: parent, depth and chain head per node, one write and one read port.
// Depends on hld_pkg. Entries are undefined until written; out-of-range nodes read as zero.
`default_nettype none

module hld_table
   import hld_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire tbl_wr_type wr_req,
   input  wire tbl_rd_type rd_req,
   output      entry_type  rd_data
);

   localparam int ADDR_W = $clog2(MAX_NODES);

   entry_type         mem_ff [MAX_NODES];
   entry_type         q_ff;
   logic              in_range_ff;
   logic              wr_in_range;
   logic              rd_in_range;
   logic [ADDR_W-1:0] wr_idx;
   logic [ADDR_W-1:0] rd_idx;

   assign wr_in_range = (32'(wr_req.node) < 32'(MAX_NODES));
   assign rd_in_range = (32'(rd_req.node) < 32'(MAX_NODES));
   assign wr_idx      = ADDR_W'(wr_req.node);
   assign rd_idx      = ADDR_W'(rd_req.node);

   always_ff @(posedge clock) begin
      if (wr_req.en && wr_in_range) begin
         mem_ff[wr_idx] <= wr_req.entry;
      end
      if (rd_req.en) begin
         q_ff <= mem_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_range_ff <= 1'b0;
      end else if (rd_req.en) begin
         in_range_ff <= rd_in_range;
      end
   end

   // A node beyond the table reads as an all-zero entry.
   assign rd_data = in_range_ff ? q_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/core/hld_walk.sv
// Chain climbing sequencer with one shared comparator, reading the node table serially.
// Depends on hld_pkg and assert_macros.svh; drives the read port of hld_table.
`default_nettype none
`include "assert_macros.svh"

module hld_walk
   import hld_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire node_type     node_a,
   input  wire node_type     node_b,
   output      tbl_rd_type   rd_req,
   input  wire entry_type    rd_data,
   input  wire logic         done_ack,
   output      walk_sts_type sts
);

   localparam int JUMP_W = $clog2(2 * MAX_NODES + 1);
   localparam logic [JUMP_W-1:0] JUMP_LIMIT = JUMP_W'(2 * MAX_NODES);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GET_HA,
      ST_GET_HB,
      ST_CHECK,
      ST_GET_DHA,
      ST_GET_DHB,
      ST_MOVE,
      ST_NEW_HA,
      ST_NEW_HB,
      ST_FIN_A,
      ST_FIN_B,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [JUMP_W-1:0] jumps_ff, jumps_in;
   node_type          a_ff, a_in;
   node_type          b_ff, b_in;
   node_type          ha_ff, ha_in;
   node_type          hb_ff, hb_in;
   node_type          dha_ff, dha_in;
   node_type          pha_ff, pha_in;
   node_type          dhb_ff, dhb_in;
   node_type          phb_ff, phb_in;
   node_type          da_ff, da_in;
   node_type          ancestor_ff, ancestor_in;

   node_type          cmp_x;
   node_type          cmp_y;
   logic              cmp_eq;
   logic              cmp_lt;

   // The one comparator, shared by the head match, the head depth race and the final pick.
   assign cmp_eq = (cmp_x == cmp_y);
   assign cmp_lt = (cmp_x < cmp_y);

   always_comb begin
      state_in    = state_ff;
      jumps_in    = jumps_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      ha_in       = ha_ff;
      hb_in       = hb_ff;
      dha_in      = dha_ff;
      pha_in      = pha_ff;
      dhb_in      = dhb_ff;
      phb_in      = phb_ff;
      da_in       = da_ff;
      ancestor_in = ancestor_ff;
      rd_req.en   = 1'b0;
      rd_req.node = a_ff;
      cmp_x       = ha_ff;
      cmp_y       = hb_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               a_in        = node_a;
               b_in        = node_b;
               jumps_in    = '0;
               rd_req.en   = 1'b1;
               rd_req.node = node_a;
               state_in    = ST_GET_HA;
            end
         end
         ST_GET_HA: begin
            ha_in       = rd_data.head;
            rd_req.en   = 1'b1;
            rd_req.node = b_ff;
            state_in    = ST_GET_HB;
         end
         ST_GET_HB: begin
            hb_in    = rd_data.head;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmp_x     = ha_ff;
            cmp_y     = hb_ff;
            rd_req.en = 1'b1;
            // A runaway climb over inconsistent tables stops at the jump limit.
            if (cmp_eq || (jumps_ff == JUMP_LIMIT)) begin
               rd_req.node = a_ff;
               state_in    = ST_FIN_A;
            end else begin
               rd_req.node = ha_ff;
               state_in    = ST_GET_DHA;
            end
         end
         ST_GET_DHA: begin
            dha_in      = rd_data.depth;
            pha_in      = rd_data.parent;
            rd_req.en   = 1'b1;
            rd_req.node = hb_ff;
            state_in    = ST_GET_DHB;
         end
         ST_GET_DHB: begin
            dhb_in   = rd_data.depth;
            phb_in   = rd_data.parent;
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            cmp_x     = dha_ff;
            cmp_y     = dhb_ff;
            jumps_in  = jumps_ff + JUMP_W'(1);
            rd_req.en = 1'b1;
            // The node under the deeper head moves; on a tie the first node moves.
            if (cmp_lt) begin
               b_in        = phb_ff;
               rd_req.node = phb_ff;
               state_in    = ST_NEW_HB;
            end else begin
               a_in        = pha_ff;
               rd_req.node = pha_ff;
               state_in    = ST_NEW_HA;
            end
         end
         ST_NEW_HA: begin
            ha_in    = rd_data.head;
            state_in = ST_CHECK;
         end
         ST_NEW_HB: begin
            hb_in    = rd_data.head;
            state_in = ST_CHECK;
         end
         ST_FIN_A: begin
            da_in       = rd_data.depth;
            rd_req.en   = 1'b1;
            rd_req.node = b_ff;
            state_in    = ST_FIN_B;
         end
         ST_FIN_B: begin
            cmp_x       = da_ff;
            cmp_y       = rd_data.depth;
            ancestor_in = cmp_lt ? a_ff : b_ff;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (done_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         jumps_ff <= '0;
      end else begin
         state_ff <= state_in;
         jumps_ff <= jumps_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      ha_ff       <= ha_in;
      hb_ff       <= hb_in;
      dha_ff      <= dha_in;
      pha_ff      <= pha_in;
      dhb_ff      <= dhb_in;
      phb_ff      <= phb_in;
      da_ff       <= da_in;
      ancestor_ff <= ancestor_in;
   end

   assign sts.busy     = (state_ff != ST_IDLE);
   assign sts.done     = (state_ff == ST_DONE);
   assign sts.ancestor = ancestor_ff;

   `ASSERT_ALWAYS(a_start_when_idle, clock, reset, start |-> (state_ff == ST_IDLE), "query started while busy")
   `ASSERT_ALWAYS(a_jump_bound, clock, reset, jumps_ff <= JUMP_LIMIT, "jump count past its limit")
   `ASSERT_ALWAYS(a_done_hold, clock, reset, ((state_ff == ST_DONE) && !done_ack) |=> ((state_ff == ST_DONE) && $stable(ancestor_ff)), "result lost before transfer")
   `ASSERT_NEVER(a_idle_read, clock, reset, rd_req.en && (state_ff == ST_IDLE) && !start, "table read while idle")

endmodule

`default_nettype wire

FILE: rtl/core/hld_lca_query.sv
// A query reads both chain heads, then for each chain jump reads both head entries and moves
// one node, then reads both depths; no request is taken until its result moves to the output.
// One table write per cycle is taken while no query is in flight; the single table read port
// sets the pace of the climb. A finished result waits in the output register while the next
// request is taken. Reset clears the sequencer and output valid; the node tables keep their
// contents and hold undefined data until written.
`default_nettype none
`include "assert_macros.svh"

module hld_lca_query
   import hld_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // node_a[9:0], node_b[19:10], parent_node[29:20], node_depth[39:30], chain_head[49:40]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // kind[0]
   input  wire logic                  req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // ancestor[9:0]
   output      logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic         req_xfer;
   tbl_wr_type   wr_req;
   tbl_rd_type   rd_req;
   entry_type    rd_data;
   walk_sts_type sts;
   logic         start;
   logic         done_ack;
   logic         rsp_load;
   logic         rsp_valid_ff, rsp_valid_in;
   node_type     rsp_ancestor_ff;

   assign req_tready = !sts.busy;
   assign req_xfer   = req_tvalid && req_tready;
   assign start      = req_xfer && (req_tuser == KIND_QUERY);

   assign wr_req.en           = req_xfer && (req_tuser == KIND_WRITE);
   assign wr_req.node         = req_tdata[NODE_W-1:0];
   assign wr_req.entry.parent = req_tdata[3*NODE_W-1:2*NODE_W];
   assign wr_req.entry.depth  = req_tdata[4*NODE_W-1:3*NODE_W];
   assign wr_req.entry.head   = req_tdata[5*NODE_W-1:4*NODE_W];

   hld_table #(
      .MAX_NODES(MAX_NODES)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .wr_req (wr_req),
      .rd_req (rd_req),
      .rd_data(rd_data)
   );

   hld_walk #(
      .MAX_NODES(MAX_NODES)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .node_a  (req_tdata[NODE_W-1:0]),
      .node_b  (req_tdata[2*NODE_W-1:NODE_W]),
      .rd_req  (rd_req),
      .rd_data (rd_data),
      .done_ack(done_ack),
      .sts     (sts)
   );

   // The output register frees as its transfer happens, so a result can move in behind it.
   assign done_ack     = !rsp_valid_ff || rsp_tready;
   assign rsp_load     = sts.done && done_ack;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_ancestor_ff <= sts.ancestor;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ancestor_ff);

   `ASSERT_ALWAYS(a_query_busy, clock, reset, start |=> !req_tready, "query transfer left the block ready")
   `ASSERT_NEVER(a_write_while_busy, clock, reset, wr_req.en && sts.busy, "table write during a climb")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for hld_lca_query: table writes and ancestor queries on stream ports.
// Depends on hld_pkg and the hld_lca_query RTL; answers are predicted by a climb over local tables.
module testbench
   import hld_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1350;
   localparam int TAIL_START  = ITEM_TARGET * 9 / 10;
   localparam int MAX_TREE    = 200;
   localparam int NO_ANSWER   = -1;

   typedef struct {
      logic     kind;
      node_type node_a;
      node_type node_b;
      node_type parent;
      node_type depth;
      node_type head;
      int       answer;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Local copy of the node tables, updated as each write transfer is accepted.
   node_type parent_of [DEF_MAX_NODES];
   node_type depth_of [DEF_MAX_NODES];
   node_type head_of [DEF_MAX_NODES];
   bit       is_written [DEF_MAX_NODES];
   node_type written_nodes [$];

   node_type pending_ancestors [$];
   int       mismatches  = 0;
   int       items_sent  = 0;
   bit       quiet_tail  = 0;
   bit       sender_calm = 0;

   hld_lca_query i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Climb chain by chain until both nodes share a head; a broken table ends at the jump limit.
   function automatic node_type climb_to_ancestor(node_type a, node_type b);
      node_type ha;
      node_type hb;
      int       jumps;
      for (jumps = 0; jumps < 2 * DEF_MAX_NODES; jumps++) begin
         ha = head_of[a];
         hb = head_of[b];
         if (ha == hb) break;
         if (depth_of[ha] < depth_of[hb]) b = parent_of[hb];
         else a = parent_of[ha];
      end
      return (depth_of[a] < depth_of[b]) ? a : b;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer, valid still high.
   task automatic send_item(logic kind, node_type a, node_type b, node_type p, node_type d,
                            node_type h, int answer);
      if (!quiet_tail && !sender_calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, h, d, p, b, a};
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_WRITE) begin
         parent_of[a] = p;
         depth_of[a]  = d;
         head_of[a]   = h;
         if (!is_written[a]) begin
            is_written[a] = 1'b1;
            written_nodes.insert(written_nodes.size(), a);
         end
      end else begin
         pending_ancestors.insert(pending_ancestors.size(),
                                  answer >= 0 ? node_type'(answer) : climb_to_ancestor(a, b));
      end
      items_sent++;
      if (items_sent >= TAIL_START) quiet_tail = 1'b1;
      @(negedge clock);
   endtask

   task automatic wait_for_answers();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_ancestors.size() != 0);
   endtask

   // Result side: stalls come in bursts, with long ready stretches in between.
   initial begin
      int run;
      bit level;
      run   = 0;
      level = 1'b1;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (run == 0) begin
            if (!quiet_tail && level && $urandom_range(0, 2) == 0) begin
               level = 1'b0;
               run   = $urandom_range(1, 10);
            end else begin
               level = 1'b1;
               run   = $urandom_range(1, 40);
            end
         end
         run--;
         rsp_tready <= level;
      end
   end

   always @(posedge clock) begin
      node_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_ancestors.size() == 0) begin
            $display("%0t: ancestor %0d arrived with no query outstanding", $time,
                     rsp_tdata[NODE_W-1:0]);
            mismatches++;
         end else begin
            want = pending_ancestors.pop_front();
            if (rsp_tdata[NODE_W-1:0] !== want) begin
               $display("%0t: ancestor expected %0d, actual %0d", $time, want,
                        rsp_tdata[NODE_W-1:0]);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #1_000_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      directed_row_type directed_rows [20];
      node_type ids [MAX_TREE];
      int       up [MAX_TREE];
      int       subtree [MAX_TREE];
      int       heavy [MAX_TREE];
      int       order [MAX_TREE];
      node_type level_of [MAX_TREE];
      node_type top_of [MAX_TREE];
      bit       taken [DEF_MAX_NODES];
      int       n;
      int       i;
      int       j;
      int       t;
      int       x;
      int       y;

      // Small tree rooted at 1023, plus a two-node loop and a self-parent node.
      directed_rows = '{
         '{KIND_WRITE, 1023,    0,    0,    1, 1023, NO_ANSWER},
         '{KIND_WRITE,    5, 1023, 1023,    2, 1023, NO_ANSWER},
         '{KIND_WRITE,    6,    0, 1023,    2,    6, NO_ANSWER},
         '{KIND_WRITE,    7, 1023,    5,    3,    7, NO_ANSWER},
         '{KIND_WRITE,    0,    0,    6,    3,    6, NO_ANSWER},
         '{KIND_WRITE,    9,    0,    5,    3,    9, NO_ANSWER},
         // A second heavy child of the root: equal depth on one chain.
         '{KIND_WRITE,   10,    0, 1023,    2, 1023, NO_ANSWER},
         '{KIND_WRITE,    1, 1023,    2,    0,    1, NO_ANSWER},
         '{KIND_WRITE,    2,    0,    1,    0,    2, NO_ANSWER},
         '{KIND_WRITE,    3,    0,    3, 1023,    3, NO_ANSWER},
         '{KIND_QUERY, 1023, 1023,    0,    0,    0, 1023},
         '{KIND_QUERY,    5, 1023,    0,    0,    0, 1023},
         '{KIND_QUERY,    7,    0,    0,    0,    0, NO_ANSWER},
         '{KIND_QUERY,    0,    5,    0,    0,    0, NO_ANSWER},
         '{KIND_QUERY,    7,    5,    0,    0,    0, NO_ANSWER},
         '{KIND_QUERY,    5,    6,    0,    0,    0, NO_ANSWER},
         // Both chain heads at the same depth: the first node climbs.
         '{KIND_QUERY,    7,    9,    0,    0,    0, NO_ANSWER},
         '{KIND_QUERY,    5,   10,    0,    0,    0, 10},
         '{KIND_QUERY,   10,    5,    0,    0,    0, 5},
         // The self-parent node never reaches the loop, so the climb runs out of jumps.
         '{KIND_QUERY,    1,    3,    0,    0,    0, NO_ANSWER}
      };

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_WRITE;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_item(directed_rows[r].kind, directed_rows[r].node_a, directed_rows[r].node_b,
                   directed_rows[r].parent, directed_rows[r].depth, directed_rows[r].head,
                   directed_rows[r].answer);
      wait_for_answers();

      while (items_sent < ITEM_TARGET) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) wait_for_answers();

         // Random tree on distinct node numbers; index 0 is the root.
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, MAX_TREE) : $urandom_range(2, 30);
         foreach (taken[k]) taken[k] = 1'b0;
         for (i = 0; i < n; i++) begin
            do x = $urandom_range(0, DEF_MAX_NODES - 1); while (taken[x]);
            taken[x] = 1'b1;
            ids[i]     = node_type'(x);
            up[i]      = (i == 0) ? 0 : ($urandom_range(0, 2) == 0 ? i - 1 : $urandom_range(0, i - 1));
            subtree[i] = 1;
            heavy[i]   = -1;
            order[i]   = i;
         end
         for (i = n - 1; i >= 1; i--) subtree[up[i]] += subtree[i];
         for (i = 1; i < n; i++)
            if (heavy[up[i]] < 0 || subtree[i] > subtree[heavy[up[i]]]) heavy[up[i]] = i;
         level_of[0] = 1;
         top_of[0]   = ids[0];
         for (i = 1; i < n; i++) begin
            level_of[i] = node_type'(level_of[up[i]] + 1);
            top_of[i]   = (heavy[up[i]] == i) ? top_of[up[i]] : ids[i];
         end
         for (i = n - 1; i >= 1; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
         end

         // The root points at node 0 as the sentinel; node 0 always holds a written entry.
         for (i = 0; i < n; i++) begin
            t = order[i];
            send_item(KIND_WRITE, ids[t], node_type'($urandom), (t == 0) ? node_type'(0) : ids[up[t]],
                      level_of[t], top_of[t], NO_ANSWER);
         end
         repeat ($urandom_range(4, 24)) begin
            x = $urandom_range(0, n - 1);
            y = ($urandom_range(0, 9) == 0) ? x : $urandom_range(0, n - 1);
            send_item(KIND_QUERY, ids[x], ids[y], node_type'($urandom), node_type'($urandom),
                      node_type'($urandom), NO_ANSWER);
         end

         // Now and then corrupt a few entries, pointing only at written nodes, and query.
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3))
               send_item(KIND_WRITE,
                         written_nodes[$urandom_range(0, written_nodes.size() - 1)],
                         node_type'($urandom),
                         written_nodes[$urandom_range(0, written_nodes.size() - 1)],
                         node_type'($urandom_range(0, DEF_MAX_NODES - 1)),
                         written_nodes[$urandom_range(0, written_nodes.size() - 1)],
                         NO_ANSWER);
            repeat ($urandom_range(1, 3))
               send_item(KIND_QUERY,
                         written_nodes[$urandom_range(0, written_nodes.size() - 1)],
                         written_nodes[$urandom_range(0, written_nodes.size() - 1)],
                         node_type'($urandom), node_type'($urandom), node_type'($urandom),
                         NO_ANSWER);
         end
      end

      wait_for_answers();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
